// ===== src/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg
// Opcodes and status codes shared by the vector unit modules.
// ----------------------------------------------------------------------------
package v3alu_pkg;
   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_CROSS = 3'd2;
   localparam logic [2:0] OP_SCALE = 3'd3;
   localparam logic [2:0] OP_NORM = 3'd4;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
endpackage

// ===== src/vector3_fixed_point_alu_core.sv =====
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_core
// Three component lanes after a length unit, merged with saturation.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled; the square root
// and divider stages are fully pipelined, so a stalled output only freezes the pipeline.
// Reset clears all valid flags; data registers are not reset.
module vector3_fixed_point_alu_core import v3alu_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_opcode,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_a_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_x,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_y,
   input  logic signed [COMPONENT_WIDTH-1:0] req_b_z,
   input  logic signed [COMPONENT_WIDTH-1:0] req_scale_factor,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_x,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_y,
   output logic signed [COMPONENT_WIDTH-1:0] rsp_r_z,
   output logic [1:0]                        rsp_status
);
   localparam int CW = COMPONENT_WIDTH;
   localparam int LD = CW + 2;
   localparam int QW = CW + FRAC_BITS + 1;
   localparam int ND = LD + QW + 1;
   localparam int WW = 2 * CW + 2;

   // Stage 0..LD-1 length unit, then 0..QW lanes, then the output register.
   logic [ND:0] vld_ff, vld_in;
   logic [ND:0] adv;
   logic signed [CW-1:0] d_ff [0:LD-1][0:6];
   logic [2:0]           o_ff [0:LD-1];
   logic [CW-1:0]        len;
   logic signed [WW-1:0] w [0:2];
   logic [2:0]           op_l [0:2];
   logic [CW-1:0]        len_q_ff [0:QW];
   logic signed [CW-1:0] r_ff [0:2];
   logic [1:0]           st_ff;
   logic [CW-1:0]        rc [0:2];
   logic [2:0]           satv;
   logic signed [WW-1:0] maxv, minv;

   assign maxv = WW'((CW)'({1'b0, {(CW-1){1'b1}}}));
   assign minv = -maxv - WW'(1);

   always_comb begin
      adv[ND] = !vld_ff[ND] || rsp_ready;
      for (int i = ND - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = vld_ff;
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i <= ND; i++) begin
         if (adv[i]) vld_in[i] = vld_ff[i-1];
         if (adv[i] && !adv[i-1]) vld_in[i-1] = 1'b0;
      end
      if (rsp_ready && vld_ff[ND] && !adv[ND-1]) vld_in[ND] = 1'b0;
   end

   // Item enters stage 0 directly from the ports.
   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         d_ff[0][0] <= req_a_x; d_ff[0][1] <= req_a_y; d_ff[0][2] <= req_a_z;
         d_ff[0][3] <= req_b_x; d_ff[0][4] <= req_b_y; d_ff[0][5] <= req_b_z;
         d_ff[0][6] <= req_scale_factor;
         o_ff[0] <= req_opcode;
      end
      for (int i = 1; i < LD; i++) begin
         if (adv[i]) begin
            d_ff[i] <= d_ff[i-1];
            o_ff[i] <= o_ff[i-1];
         end
      end
   end

   v3alu_length #(.COMPONENT_WIDTH(CW)) u_len (
      .clock(clock), .adv(adv[LD-1:0]),
      .a_x(req_a_x), .a_y(req_a_y), .a_z(req_a_z), .len(len));

   always_ff @(posedge clock) begin
      if (adv[LD]) len_q_ff[0] <= len;
      for (int i = 1; i <= QW; i++) begin
         if (adv[LD+i]) len_q_ff[i] <= len_q_ff[i-1];
      end
   end

   v3alu_lane #(.FRAC_BITS(FRAC_BITS), .COMPONENT_WIDTH(CW)) u_lx (
      .clock(clock), .adv(adv[ND-1:LD]), .opcode(o_ff[LD-1]),
      .a0(d_ff[LD-1][0]), .a1(d_ff[LD-1][1]), .a2(d_ff[LD-1][2]),
      .b1(d_ff[LD-1][(o_ff[LD-1] == OP_CROSS) ? 4 : 3]),
      .b2(d_ff[LD-1][5]), .sf(d_ff[LD-1][6]), .len(len),
      .wide_out(w[0]), .op_out(op_l[0]));
   v3alu_lane #(.FRAC_BITS(FRAC_BITS), .COMPONENT_WIDTH(CW)) u_ly (
      .clock(clock), .adv(adv[ND-1:LD]), .opcode(o_ff[LD-1]),
      .a0(d_ff[LD-1][1]), .a1(d_ff[LD-1][2]), .a2(d_ff[LD-1][0]),
      .b1(d_ff[LD-1][(o_ff[LD-1] == OP_CROSS) ? 5 : 4]),
      .b2(d_ff[LD-1][3]), .sf(d_ff[LD-1][6]), .len(len),
      .wide_out(w[1]), .op_out(op_l[1]));
   v3alu_lane #(.FRAC_BITS(FRAC_BITS), .COMPONENT_WIDTH(CW)) u_lz (
      .clock(clock), .adv(adv[ND-1:LD]), .opcode(o_ff[LD-1]),
      .a0(d_ff[LD-1][2]), .a1(d_ff[LD-1][0]), .a2(d_ff[LD-1][1]),
      .b1(d_ff[LD-1][(o_ff[LD-1] == OP_CROSS) ? 3 : 5]),
      .b2(d_ff[LD-1][4]), .sf(d_ff[LD-1][6]), .len(len),
      .wide_out(w[2]), .op_out(op_l[2]));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         satv[k] = (w[k] > maxv) || (w[k] < minv);
         rc[k] = (w[k] > maxv) ? maxv[CW-1:0] : (w[k] < minv) ? minv[CW-1:0] : w[k][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ND]) begin
         if (op_l[0] > OP_NORM || (op_l[0] == OP_NORM && len_q_ff[QW] == '0)) begin
            r_ff[0] <= '0; r_ff[1] <= '0; r_ff[2] <= '0;
            st_ff <= (op_l[0] == OP_NORM) ? ST_ZERO : ST_OK;
         end else begin
            r_ff[0] <= rc[0]; r_ff[1] <= rc[1]; r_ff[2] <= rc[2];
            st_ff <= (|satv) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp_valid = vld_ff[ND];
   assign rsp_r_x = r_ff[0];
   assign rsp_r_y = r_ff[1];
   assign rsp_r_z = r_ff[2];
   assign rsp_status = st_ff;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_SAT || rsp_status == ST_ZERO))
      else $error("status out of range");
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO) |-> (rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0))
      else $error("zero-length result not cleared");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_r_x)))
      else $error("result lost under stall");
endmodule

// ===== src/v3alu_lane.sv =====
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: add, subtract, cross term, scale and normalize
// division, pipelined over a fixed number of stages.
// ----------------------------------------------------------------------------
module v3alu_lane import v3alu_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int COMPONENT_WIDTH = 32,
   parameter int QW = COMPONENT_WIDTH + FRAC_BITS + 1
) (
   input  logic                              clock,
   input  logic [QW:0]                       adv,
   input  logic [2:0]                        opcode,
   input  logic signed [COMPONENT_WIDTH-1:0] a0,
   input  logic signed [COMPONENT_WIDTH-1:0] a1,
   input  logic signed [COMPONENT_WIDTH-1:0] a2,
   input  logic signed [COMPONENT_WIDTH-1:0] b1,
   input  logic signed [COMPONENT_WIDTH-1:0] b2,
   input  logic signed [COMPONENT_WIDTH-1:0] sf,
   input  logic [COMPONENT_WIDTH-1:0]        len,
   output logic signed [2*COMPONENT_WIDTH+1:0] wide_out,
   output logic [2:0]                        op_out
);
   // a0 is this lane's component of a; a1/a2 and b1/b2 pair for the cross term.
   localparam int CW = COMPONENT_WIDTH;
   localparam int WW = 2 * CW + 2;
   localparam int NW = CW + FRAC_BITS;

   logic signed [WW-1:0] res_ff [0:QW];
   logic [2:0]           op_ff [0:QW];
   logic [NW-1:0]        num_ff [0:QW];
   logic [CW:0]          rem_ff [0:QW];
   logic [NW-1:0]        quo_ff [0:QW];
   logic                 neg_ff [0:QW];
   logic [CW-1:0]        len_ff [0:QW];
   logic signed [WW-1:0] res_in;
   logic [CW-1:0]        mag;
   logic [CW:0]          rem_in [1:QW];
   logic [CW:0]          trial  [1:QW];

   always_comb begin
      res_in = '0;
      case (opcode)
         OP_ADD: res_in = WW'(a0) + WW'(b1);
         OP_SUB: res_in = WW'(a0) - WW'(b1);
         OP_CROSS: res_in = (WW'(a1) * WW'(b2) - WW'(a2) * WW'(b1)) >>> FRAC_BITS;
         OP_SCALE: res_in = (WW'(a0) * WW'(sf)) >>> FRAC_BITS;
         default: res_in = '0;
      endcase
      mag = a0[CW-1] ? CW'(-a0) : CW'(a0);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         res_ff[0] <= res_in;
         op_ff[0] <= opcode;
         num_ff[0] <= {mag, FRAC_BITS'(0)};
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         neg_ff[0] <= a0[CW-1];
         len_ff[0] <= len;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_div
      localparam int BI = (NW - s >= 0) ? NW - s : 0;
      always_comb begin
         if (s <= NW) begin
            trial[s] = {rem_ff[s-1][CW-1:0], num_ff[s-1][BI]};
            rem_in[s] = (trial[s] >= {1'b0, len_ff[s-1]}) ?
                        trial[s] - {1'b0, len_ff[s-1]} : trial[s];
         end else begin
            trial[s] = rem_ff[s-1];
            rem_in[s] = rem_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            op_ff[s] <= op_ff[s-1];
            num_ff[s] <= num_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            len_ff[s] <= len_ff[s-1];
            rem_ff[s] <= rem_in[s];
            if (s <= NW) begin
               quo_ff[s] <= quo_ff[s-1] | (NW'(trial[s] >= {1'b0, len_ff[s-1]}) << BI);
            end else begin
               quo_ff[s] <= quo_ff[s-1];
            end
            if (s > NW && op_ff[s-1] == OP_NORM) begin
               res_ff[s] <= neg_ff[s-1] ? -WW'(quo_ff[s-1]) : WW'(quo_ff[s-1]);
            end else begin
               res_ff[s] <= res_ff[s-1];
            end
         end
      end
   end

   assign wide_out = res_ff[QW];
   assign op_out = op_ff[QW];
endmodule

// ===== src/v3alu_length.sv =====
// ----------------------------------------------------------------------------
// v3alu_length
// Vector length: sum of squares, then a bit-per-stage square root.
// ----------------------------------------------------------------------------
module v3alu_length import v3alu_pkg::*; #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic [COMPONENT_WIDTH+1:0]        adv,
   input  logic signed [COMPONENT_WIDTH-1:0] a_x,
   input  logic signed [COMPONENT_WIDTH-1:0] a_y,
   input  logic signed [COMPONENT_WIDTH-1:0] a_z,
   output logic [COMPONENT_WIDTH-1:0]        len
);
   localparam int CW = COMPONENT_WIDTH;
   localparam int SW = 2 * CW + 2;

   logic [SW-1:0] sq_ff [0:CW+1];
   logic [CW:0]   root_ff [0:CW+1];
   logic [CW:0]   cand [1:CW+1];
   logic [2*CW+1:0] csq [1:CW+1];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sq_ff[0] <= SW'(SW'(a_x) * SW'(a_x)) + SW'(SW'(a_y) * SW'(a_y))
                     + SW'(SW'(a_z) * SW'(a_z));
         root_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s <= CW + 1; s++) begin : g_sqrt
      always_comb begin
         cand[s] = root_ff[s-1] | ((CW + 1)'(1) << (CW + 1 - s));
         csq[s] = cand[s] * cand[s];
      end
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            sq_ff[s] <= sq_ff[s-1];
            root_ff[s] <= (csq[s] <= sq_ff[s-1]) ? cand[s] : root_ff[s-1];
         end
      end
   end

   assign len = root_ff[CW+1][CW-1:0];
endmodule

// ===== bench/tb_vector3_fixed_point_alu_core.sv =====
// ----------------------------------------------------------------------------
// Vector unit testbench
// Drives opcode and operand transactions through the valid/ready request
// channel with random idling, predicts each result in the bench and compares
// every response field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
class vec_result_board;
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         st;
   } vec_result_t;

   vec_result_t pending[$];
   int          mismatches;

   function automatic logic signed [31:0] clamp(logic signed [127:0] v, ref bit flag);
      if (v > 128'sd2147483647) begin
         flag = 1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         flag = 1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [63:0] root(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (128'(t) * 128'(t) <= n) r = t;
      end
      return r;
   endfunction

   function void note_request(logic [2:0] op, logic signed [31:0] ax, ay, az,
                              bx, by, bz, sf);
      logic signed [127:0] w[3];
      logic signed [127:0] a[3];
      logic [127:0]        sq;
      logic [63:0]         len;
      logic [127:0]        q;
      bit                  flag;
      vec_result_t         e;
      flag = 0;
      e = '0;
      a[0] = ax;
      a[1] = ay;
      a[2] = az;
      case (op)
         v3alu_pkg::OP_ADD: begin
            w[0] = a[0] + bx; w[1] = a[1] + by; w[2] = a[2] + bz;
         end
         v3alu_pkg::OP_SUB: begin
            w[0] = a[0] - bx; w[1] = a[1] - by; w[2] = a[2] - bz;
         end
         v3alu_pkg::OP_CROSS: begin
            w[0] = (a[1] * bz - a[2] * by) >>> 16;
            w[1] = (a[2] * bx - a[0] * bz) >>> 16;
            w[2] = (a[0] * by - a[1] * bx) >>> 16;
         end
         v3alu_pkg::OP_SCALE: begin
            for (int k = 0; k < 3; k++) w[k] = (a[k] * sf) >>> 16;
         end
         v3alu_pkg::OP_NORM: begin
            sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            len = root(sq);
            if (len == 0) e.st = v3alu_pkg::ST_ZERO;
            for (int k = 0; k < 3 && len != 0; k++) begin
               q = ((a[k] < 0) ? -a[k] : a[k]) << 16;
               q = q / len;
               w[k] = (a[k] < 0) ? -$signed(q) : $signed(q);
            end
         end
         default: e.st = v3alu_pkg::ST_OK;
      endcase
      if (op <= v3alu_pkg::OP_NORM && e.st != v3alu_pkg::ST_ZERO) begin
         e.x = clamp(w[0], flag);
         e.y = clamp(w[1], flag);
         e.z = clamp(w[2], flag);
         e.st = flag ? v3alu_pkg::ST_SAT : v3alu_pkg::ST_OK;
      end
      pending.push_back(e);
   endfunction

   function void check_response(logic signed [31:0] x, y, z, logic [1:0] st);
      vec_result_t e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected response %h %h %h %0d", x, y, z, st);
         return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.z !== z || e.st !== st) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %0d, got %h %h %h %0d",
                     e.x, e.y, e.z, e.st, x, y, z, st);
      end
   endfunction
endclass

module tb_vector3_fixed_point_alu_core;
   import v3alu_pkg::*;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [2:0]          req_opcode = 0;
   logic signed [31:0]  req_a_x = 0, req_a_y = 0, req_a_z = 0;
   logic signed [31:0]  req_b_x = 0, req_b_y = 0, req_b_z = 0;
   logic signed [31:0]  req_scale_factor = 0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic signed [31:0]  rsp_r_x, rsp_r_y, rsp_r_z;
   logic [1:0]          rsp_status;
   int                  send_idle = 31;
   int                  recv_idle = 45;
   vec_result_board     board = new();

   vector3_fixed_point_alu_core u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response(rsp_r_x, rsp_r_y, rsp_r_z, rsp_status);
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3, 4: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic [2:0] op, logic signed [31:0] ax, ay, az, bx, by, bz, sf);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_a_x <= ax; req_a_y <= ay; req_a_z <= az;
      req_b_x <= bx; req_b_y <= by; req_b_z <= bz;
      req_scale_factor <= sf;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, ax, ay, az, bx, by, bz, sf);
   endtask

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic signed [31:0] mx, mn;
      mx = 32'sh7fffffff;
      mn = 32'sh80000000;
      repeat (4) @(posedge clock);
      reset <= 0;
      send(OP_ADD, mx, mn, 1, 1, -1, -1, 0);
      send(OP_ADD, mx, mn, 0, mx, mn, 0, 0);
      send(OP_SUB, mn, mx, 0, 1, -1, 0, 0);
      send(OP_SUB, 32'sh10000, 2, 3, 4, 5, 6, 0);
      send(OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0);
      send(OP_CROSS, mx, mn, mx, mn, mx, mn, 0);
      send(OP_CROSS, -1, 1, -1, 1, 3, -5, 0);
      send(OP_SCALE, mx, mn, -1, 0, 0, 0, mn);
      send(OP_SCALE, 32'sh18000, -32'sh18000, 1, 0, 0, 0, 32'sh8000);
      send(OP_SCALE, -1, 1, 3, 0, 0, 0, -1);
      send(OP_NORM, 0, 0, 0, 5, 5, 5, 5);
      send(OP_NORM, 1, 0, 0, 0, 0, 0, 0);
      send(OP_NORM, mn, mn, mn, 0, 0, 0, 0);
      send(OP_NORM, mx, 0, 0, 0, 0, 0, 0);
      send(OP_NORM, 32'sh30000, -32'sh40000, 0, 0, 0, 0, 0);
      send(OP_NORM, -1, 0, 0, 0, 0, 0, 0);
      send(3'd5, 1, 2, 3, 4, 5, 6, 7);
      send(3'd6, mx, mx, mx, mx, mx, mx, mx);
      send(3'd7, mn, mn, mn, mn, mn, mn, mn);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
         recv_idle = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
         for (int i = 0; i < 480; i++)
            send(($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4)),
                 pick_value(), pick_value(), pick_value(), pick_value(),
                 pick_value(), pick_value(), pick_value());
      end
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
